>>> rtl/core/rfb_pkg.sv
`default_nettype none

package rfb_pkg;

    // channel lanes
    localparam int CH_NUM = 3;
    localparam int CH_R   = 0;
    localparam int CH_G   = 1;
    localparam int CH_B   = 2;

    // datapath widths
    localparam int PIX_W       = 32;
    localparam int SHIFT_W     = 5;
    localparam int MAX_W       = 16;
    localparam int DIV_W       = MAX_W + 1;
    localparam int REM_W       = MAX_W;
    localparam int Q_W         = 8;
    localparam int RGB_W       = CH_NUM * Q_W;
    localparam int STEP_BITS   = 4;
    localparam int DIV_STAGES  = PIX_W / STEP_BITS;
    localparam int PB_W        = 3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = MAX_W;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_MAX     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP        = 4'd7;

    // pixel width codes
    localparam logic [PB_W-1:0] PIX_BYTES_4 = 3'd4;
    localparam logic [PB_W-1:0] PIX_BYTES_2 = 3'd2;

    typedef struct packed {
        logic [PB_W-1:0]                     pixel_bytes;
        logic [CH_NUM-1:0][SHIFT_W-1:0]      shift;
        logic [CH_NUM-1:0][MAX_W-1:0]        max;
        logic                                swap;
    } t_cfg;

    // one channel in flight through the divider
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [PIX_W-1:0] num;
        logic [Q_W-1:0]   quot;
    } t_lane;

    typedef t_lane [CH_NUM-1:0]             t_lane_set;
    typedef logic  [CH_NUM-1:0][DIV_W-1:0]  t_div_set;

endpackage

`default_nettype wire

>>> rtl/core/rfb_prep.sv
`default_nettype none

module rfb_prep (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [rfb_pkg::PIX_W-1:0]   i_pixel_word,
    input  wire rfb_pkg::t_cfg               i_cfg,
    output logic                             o_valid,
    output rfb_pkg::t_lane_set               o_lanes
);

    logic                       r_valid;
    rfb_pkg::t_lane_set         r_lanes;
    rfb_pkg::t_lane_set         n_lanes;
    logic [rfb_pkg::PIX_W-1:0]  pix;

    // width select, then shift and scale by 256 with 32-bit wrap
    always_comb begin
        case (i_cfg.pixel_bytes)
            rfb_pkg::PIX_BYTES_4: pix = i_pixel_word;
            rfb_pkg::PIX_BYTES_2: pix = {16'd0, i_pixel_word[15:0]};
            default:              pix = {24'd0, i_pixel_word[7:0]};
        endcase
        for (int c = 0; c < rfb_pkg::CH_NUM; c++) begin
            logic [rfb_pkg::PIX_W-1:0] sh;
            sh = pix >> i_cfg.shift[c];
            n_lanes[c].rem  = '0;
            n_lanes[c].num  = {sh[rfb_pkg::PIX_W-9:0], 8'd0};
            n_lanes[c].quot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

>>> rtl/core/rfb_div_stage.sv
`default_nettype none

module rfb_div_stage (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire rfb_pkg::t_lane_set    i_lanes,
    input  wire rfb_pkg::t_div_set     i_div,
    output logic                       o_valid,
    output rfb_pkg::t_lane_set         o_lanes
);

    logic                  r_valid;
    rfb_pkg::t_lane_set    r_lanes;
    rfb_pkg::t_lane_set    n_lanes;

    // restoring division, a few quotient bits per stage
    always_comb begin
        for (int c = 0; c < rfb_pkg::CH_NUM; c++) begin
            logic [rfb_pkg::REM_W-1:0] rem;
            logic [rfb_pkg::PIX_W-1:0] num;
            logic [rfb_pkg::Q_W-1:0]   quot;
            logic [rfb_pkg::DIV_W-1:0] trial;
            logic [rfb_pkg::DIV_W-1:0] diff;
            rem  = i_lanes[c].rem;
            num  = i_lanes[c].num;
            quot = i_lanes[c].quot;
            for (int s = 0; s < rfb_pkg::STEP_BITS; s++) begin
                trial = {rem, num[rfb_pkg::PIX_W-1]};
                num   = {num[rfb_pkg::PIX_W-2:0], 1'b0};
                diff  = trial - i_div[c];
                if (trial >= i_div[c]) begin
                    rem  = diff[rfb_pkg::REM_W-1:0];
                    quot = {quot[rfb_pkg::Q_W-2:0], 1'b1};
                end else begin
                    rem  = trial[rfb_pkg::REM_W-1:0];
                    quot = {quot[rfb_pkg::Q_W-2:0], 1'b0};
                end
            end
            n_lanes[c].rem  = rem;
            n_lanes[c].num  = num;
            n_lanes[c].quot = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

>>> rtl/core/rfb_pixel_to_rgb24_core.sv
`default_nettype none

// true-colour pixel word to packed 24-bit rgb
//
// input: one pixel per transfer, taken on a clock edge with start high and
//   busy low; busy is held low, so a new pixel may follow every cycle
// output: o_valid marks rgb_word for exactly one cycle; the receiver has no
//   way to hold results off, and none is needed since nothing waits inside
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx on the
//   edge (indices 0..7, anything above is dropped); write only when no pixel
//   is in flight, since every stage reads the live registers
// pipeline: ten register stages - one prep register (width mask, shift,
//   scale by 256), eight divider stages of four quotient bits each over the
//   32-bit numerator, and one output register
// throughput: one pixel per cycle, fixed by the fully pipelined divider with
//   one divide lane per colour channel
// reset (synchronous, active low): clears all valid bits and returns the
//   registers to 4-byte pixels, shifts 16/8/0, max 255 and no swap
module rfb_pixel_to_rgb24_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [rfb_pkg::PIX_W-1:0]         i_pixel_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [rfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_valid,
    output logic [rfb_pkg::RGB_W-1:0]              o_rgb_word
);

    rfb_pkg::t_cfg      r_cfg;
    rfb_pkg::t_div_set  div;

    logic                 stg_valid [0:rfb_pkg::DIV_STAGES];
    rfb_pkg::t_lane_set   stg_lanes [0:rfb_pkg::DIV_STAGES];

    logic                       r_out_valid;
    logic [rfb_pkg::RGB_W-1:0]  r_rgb;
    logic [rfb_pkg::RGB_W-1:0]  n_rgb;

    // the pipeline never backs up
    assign busy = 1'b0;

    // configuration registers, values masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_bytes         <= rfb_pkg::PIX_BYTES_4;
            r_cfg.shift[rfb_pkg::CH_R] <= 5'd16;
            r_cfg.shift[rfb_pkg::CH_G] <= 5'd8;
            r_cfg.shift[rfb_pkg::CH_B] <= 5'd0;
            r_cfg.max[rfb_pkg::CH_R]   <= 16'd255;
            r_cfg.max[rfb_pkg::CH_G]   <= 16'd255;
            r_cfg.max[rfb_pkg::CH_B]   <= 16'd255;
            r_cfg.swap                 <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfb_pkg::REG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_data[2:0];
                rfb_pkg::REG_RED_SHIFT:   r_cfg.shift[rfb_pkg::CH_R] <= i_cfg_data[4:0];
                rfb_pkg::REG_GREEN_SHIFT: r_cfg.shift[rfb_pkg::CH_G] <= i_cfg_data[4:0];
                rfb_pkg::REG_BLUE_SHIFT:  r_cfg.shift[rfb_pkg::CH_B] <= i_cfg_data[4:0];
                rfb_pkg::REG_RED_MAX:     r_cfg.max[rfb_pkg::CH_R]   <= i_cfg_data;
                rfb_pkg::REG_GREEN_MAX:   r_cfg.max[rfb_pkg::CH_G]   <= i_cfg_data;
                rfb_pkg::REG_BLUE_MAX:    r_cfg.max[rfb_pkg::CH_B]   <= i_cfg_data;
                rfb_pkg::REG_SWAP:        r_cfg.swap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // divisor is max + 1, never zero; 17 bits so 65536 fits
    always_comb begin
        for (int c = 0; c < rfb_pkg::CH_NUM; c++) begin
            div[c] = {1'b0, r_cfg.max[c]} + 17'd1;
        end
    end

    // width mask, per-channel shift and scale
    rfb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start & ~busy),
        .i_pixel_word (i_pixel_word),
        .i_cfg        (r_cfg),
        .o_valid      (stg_valid[0]),
        .o_lanes      (stg_lanes[0])
    );

    // divider pipeline: each stage consumes four numerator bits; only the
    // low eight quotient bits survive, matching the byte truncation
    for (genvar k = 0; k < rfb_pkg::DIV_STAGES; k++) begin : g_div
        rfb_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_lanes (stg_lanes[k]),
            .i_div   (div),
            .o_valid (stg_valid[k+1]),
            .o_lanes (stg_lanes[k+1])
        );
    end

    // pack the three bytes, red/blue order set by the swap bit
    always_comb begin
        if (r_cfg.swap) begin
            n_rgb = {stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_B].quot,
                     stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_G].quot,
                     stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_R].quot};
        end else begin
            n_rgb = {stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_R].quot,
                     stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_G].quot,
                     stg_lanes[rfb_pkg::DIV_STAGES][rfb_pkg::CH_B].quot};
        end
    end

    // output register, one-cycle strobe per result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= stg_valid[rfb_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_valid    = r_out_valid;
    assign o_rgb_word = r_rgb;

endmodule

`default_nettype wire

>>> tb/sv/rgb24_checker.sv
`timescale 1ns / 100ps

module rgb24_checker
    import rfb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [PIX_W-1:0]      i_pixel_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_rgb_valid,
    input  wire logic [RGB_W-1:0]      i_rgb_word,
    output int                         o_fail_count,
    output int                         o_pending
);

    t_cfg             live_cfg;
    logic [RGB_W-1:0] rgb_expected[$];

    // shift, scale by 256 with 32-bit wrap, divide by max + 1, keep low byte
    function automatic logic [Q_W-1:0] channel_byte(input logic [PIX_W-1:0] used,
                                                    input logic [SHIFT_W-1:0] sh,
                                                    input logic [MAX_W-1:0] mx);
        logic [PIX_W-1:0] scaled;
        logic [PIX_W-1:0] divisor;
        logic [PIX_W-1:0] quotient;
        scaled   = (used >> sh) << 8;
        divisor  = {{(PIX_W-MAX_W){1'b0}}, mx} + 1'b1;
        quotient = scaled / divisor;
        return quotient[Q_W-1:0];
    endfunction

    function automatic logic [RGB_W-1:0] rgb24_of_pixel(input logic [PIX_W-1:0] pixel,
                                                        input t_cfg c);
        logic [PIX_W-1:0] used;
        logic [Q_W-1:0]   red;
        logic [Q_W-1:0]   green;
        logic [Q_W-1:0]   blue;
        if (c.pixel_bytes == PIX_BYTES_4) begin
            used = pixel;
        end else if (c.pixel_bytes == PIX_BYTES_2) begin
            used = {16'd0, pixel[15:0]};
        end else begin
            used = {24'd0, pixel[7:0]};
        end
        red   = channel_byte(used, c.shift[CH_R], c.max[CH_R]);
        green = channel_byte(used, c.shift[CH_G], c.max[CH_G]);
        blue  = channel_byte(used, c.shift[CH_B], c.max[CH_B]);
        return c.swap ? {blue, green, red} : {red, green, blue};
    endfunction

    always @(posedge i_clk) begin
        logic [RGB_W-1:0] want;
        if (!i_rst_n) begin
            live_cfg.pixel_bytes = PIX_BYTES_4;
            live_cfg.shift[CH_R] = 16;
            live_cfg.shift[CH_G] = 8;
            live_cfg.shift[CH_B] = 0;
            live_cfg.max[CH_R]   = 255;
            live_cfg.max[CH_G]   = 255;
            live_cfg.max[CH_B]   = 255;
            live_cfg.swap        = 1'b0;
            rgb_expected.delete();
        end else begin
            // results first: nothing taken on this edge can already be out
            if (i_rgb_valid) begin
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected rgb_word %06h", $time, i_rgb_word);
                    o_fail_count++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (i_rgb_word !== want) begin
                        $display("%0t: rgb_word expected %06h actual %06h",
                                 $time, want, i_rgb_word);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PIXEL_BYTES: live_cfg.pixel_bytes = i_cfg_data[PB_W-1:0];
                    REG_RED_SHIFT:   live_cfg.shift[CH_R] = i_cfg_data[SHIFT_W-1:0];
                    REG_GREEN_SHIFT: live_cfg.shift[CH_G] = i_cfg_data[SHIFT_W-1:0];
                    REG_BLUE_SHIFT:  live_cfg.shift[CH_B] = i_cfg_data[SHIFT_W-1:0];
                    REG_RED_MAX:     live_cfg.max[CH_R]   = i_cfg_data;
                    REG_GREEN_MAX:   live_cfg.max[CH_G]   = i_cfg_data;
                    REG_BLUE_MAX:    live_cfg.max[CH_B]   = i_cfg_data;
                    REG_SWAP:        live_cfg.swap        = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                rgb_expected.push_back(rgb24_of_pixel(i_pixel_word, live_cfg));
            end
        end
        o_pending = rgb_expected.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rfb_pkg::*;

    // odd pixel width value, taken by the block as 8-bit pixels
    localparam logic [PB_W-1:0]       PIX_BYTES_1 = 3'd1;
    localparam logic [CFG_DATA_W-1:0] NO_JUNK     = '0;
    localparam logic [CFG_DATA_W-1:0] ALL_JUNK    = '1;
    localparam int                    CYCLE_LIMIT = 100000;
    localparam int                    RAND_PHASES = 16;
    localparam int                    PHASE_ITEMS = 25;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [PIX_W-1:0]      i_pixel_word = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_valid;
    logic [RGB_W-1:0]      o_rgb_word;

    int fail_count;
    int rgb_pending;
    int cycle_count = 0;

    rfb_pixel_to_rgb24_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_word (i_pixel_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_rgb_word   (o_rgb_word)
    );

    // watches both channels and the register port, predicts and compares
    rgb24_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pixel_word (i_pixel_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_rgb_valid  (o_valid),
        .i_rgb_word   (o_rgb_word),
        .o_fail_count (fail_count),
        .o_pending    (rgb_pending)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_cfg make_setting(input logic [PB_W-1:0] pb,
                                          input int r_sh, input int g_sh, input int b_sh,
                                          input int r_mx, input int g_mx, input int b_mx,
                                          input bit sw);
        t_cfg s;
        s.pixel_bytes = pb;
        s.shift[CH_R] = SHIFT_W'(r_sh);
        s.shift[CH_G] = SHIFT_W'(g_sh);
        s.shift[CH_B] = SHIFT_W'(b_sh);
        s.max[CH_R]   = MAX_W'(r_mx);
        s.max[CH_G]   = MAX_W'(g_mx);
        s.max[CH_B]   = MAX_W'(b_mx);
        s.swap        = sw;
        return s;
    endfunction

    // pixel formats leaning on the common widths, shifts mostly in 0..16,
    // max values half the time of the 2^k - 1 form with 0 and 65535 included
    function automatic t_cfg random_setting();
        t_cfg s;
        int   k;
        case ($urandom_range(3))
            0:       s.pixel_bytes = PIX_BYTES_4;
            1:       s.pixel_bytes = PIX_BYTES_2;
            2:       s.pixel_bytes = PIX_BYTES_1;
            default: s.pixel_bytes = PB_W'($urandom);
        endcase
        for (int ch = 0; ch < CH_NUM; ch++) begin
            s.shift[ch] = ($urandom_range(3) == 0) ? SHIFT_W'($urandom)
                                                   : SHIFT_W'($urandom_range(16));
            k = $urandom_range(16);
            case ($urandom_range(3))
                0, 1:    s.max[ch] = MAX_W'((32'd1 << k) - 1);
                2:       s.max[ch] = MAX_W'($urandom);
                default: s.max[ch] = MAX_W'($urandom_range(300));
            endcase
        end
        s.swap = 1'($urandom_range(1));
        return s;
    endfunction

    // stop issuing pixels and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (rgb_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // all eight registers, with junk above each register's width; a dirty
    // setting also throws one write at an index past the last register
    task automatic apply_setting(input t_cfg s, input logic [CFG_DATA_W-1:0] junk);
        drain();
        write_reg(REG_PIXEL_BYTES, {junk[CFG_DATA_W-1:PB_W], s.pixel_bytes});
        write_reg(REG_RED_SHIFT,   {junk[CFG_DATA_W-1:SHIFT_W], s.shift[CH_R]});
        write_reg(REG_GREEN_SHIFT, {junk[CFG_DATA_W-1:SHIFT_W], s.shift[CH_G]});
        write_reg(REG_BLUE_SHIFT,  {junk[CFG_DATA_W-1:SHIFT_W], s.shift[CH_B]});
        write_reg(REG_RED_MAX,     s.max[CH_R]);
        write_reg(REG_GREEN_MAX,   s.max[CH_G]);
        write_reg(REG_BLUE_MAX,    s.max[CH_B]);
        write_reg(REG_SWAP,        {junk[CFG_DATA_W-1:1], s.swap});
        if (junk != NO_JUNK) begin
            write_reg(CFG_IDX_W'(REG_SWAP + 1 + $urandom_range(7)), junk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // one pixel transfer; optional idle cycles in front of it
    task automatic drive_pixel(input logic [PIX_W-1:0] pixel, input bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 23) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_pixel_word <= pixel;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic [PIX_W-1:0]      pixel;
        logic [CFG_DATA_W-1:0] junk;
        bit                    gaps;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values straight away: 8:8:8 in a 32-bit word
        drive_pixel(32'h0000_0000, 1'b0);
        drive_pixel(32'hFFFF_FFFF, 1'b0);
        drive_pixel(32'h00FF_8001, 1'b1);

        // 5:6:5 in 16 bits, upper half of the word must be ignored
        apply_setting(make_setting(PIX_BYTES_2, 11, 5, 0, 31, 63, 31, 1'b0), NO_JUNK);
        drive_pixel(32'hFFFF_0000, 1'b0);
        drive_pixel(32'h1234_F800, 1'b0);
        drive_pixel(32'h0000_07FF, 1'b1);

        // 3:3:2 in 8 bits, swapped, with junk in the upper register bits
        apply_setting(make_setting(PIX_BYTES_1, 5, 2, 0, 7, 7, 3, 1'b1), ALL_JUNK);
        drive_pixel(32'h1234_56E5, 1'b0);

        // odd pixel widths fall back to 8 bits
        for (int pb = 0; pb < 8; pb++) begin
            if (pb != PIX_BYTES_4 && pb != PIX_BYTES_2 && pb != PIX_BYTES_1) begin
                apply_setting(make_setting(PB_W'(pb), 4, 2, 0, 15, 3, 3, 1'b0), NO_JUNK);
                drive_pixel(32'hFFFF_FF96, 1'b0);
            end
        end

        // product wrap with max 65535, zero max with shift 31, and a quotient
        // far above a byte with max 1
        apply_setting(make_setting(PIX_BYTES_4, 0, 31, 1, 65535, 0, 1, 1'b0), NO_JUNK);
        drive_pixel(32'hFFFF_FFFF, 1'b0);
        drive_pixel(32'h8000_0001, 1'b0);

        // writes past the last register must leave the setting alone
        drain();
        for (int idx = REG_SWAP + 1; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), ALL_JUNK);
        end
        i_cfg_we <= 1'b0;
        drive_pixel(32'hFFFF_FFFF, 1'b0);

        // all junk bits set above the narrow registers' widths, masked down
        apply_setting(make_setting(PIX_BYTES_4, 31, 16, 0, 0, 255, 65535, 1'b1), ALL_JUNK);
        drive_pixel(32'hFFFF_FFFF, 1'b1);
        drive_pixel(32'h0001_0000, 1'b1);

        // random settings, each followed by a burst of random pixels; phases
        // four to seven run back to back without idle cycles
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            junk = ($urandom_range(2) == 0) ? CFG_DATA_W'($urandom) : NO_JUNK;
            apply_setting(random_setting(), junk);
            gaps = !(ph >= 4 && ph < 8);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(3))
                    0, 1:    pixel = $urandom;
                    2:       pixel = $urandom >> $urandom_range(31);
                    default: pixel = 32'hFFFF_FFFF >> $urandom_range(31);
                endcase
                drive_pixel(pixel, gaps);
            end
        end

        drain();
        // pipeline is ten deep; the extra wait catches any stray strobe
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rfb_pkg.sv
rtl/core/rfb_prep.sv
rtl/core/rfb_div_stage.sv
rtl/core/rfb_pixel_to_rgb24_core.sv
tb/sv/rgb24_checker.sv
tb/sv/testbench.sv
